// ===== rtl/sidc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sidc_pkg
// shared types and constants for the signed integer to decimal text core
// ----------------------------------------------------------------------------
package sidc_pkg;

  localparam int ValueWidth = 32;
  localparam int CharWidth = 8;
  localparam int DigitWidth = 4;
  localparam int DigitCount = 10;
  localparam int IdxWidth = 4;

  localparam logic [CharWidth-1:0] CharMinus = 8'd45;
  localparam logic [CharWidth-1:0] CharZero = 8'd48;

  // floor(x / 10) == (x * RecipTen) >> RecipShift for every 32-bit x
  localparam logic [ValueWidth-1:0] RecipTen = 32'hCCCC_CCCD;
  localparam int RecipShift = 35;

  localparam int QueueDepthDefault = 2;

  typedef logic [DigitCount-1:0][DigitWidth-1:0] digits_t;

  // one converted number waiting for the output side
  typedef struct packed {
    logic neg;
    logic [IdxWidth-1:0] top;
    digits_t digits;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

// ===== rtl/sidc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sidc_front
// takes a value, splits off the sign and peels decimal digits by reciprocal
// multiply, one digit per cycle, then hands the digit record to the queue
// ----------------------------------------------------------------------------
module sidc_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [sidc_pkg::ValueWidth-1:0]   s_tdata,   // value
  input  wire sidc_pkg::qstat_t                  q_stat,
  output logic                                   push,
  output sidc_pkg::rec_t                         push_rec
);
  import sidc_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StPush = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [ValueWidth-1:0] mag;
  logic [IdxWidth-1:0] nd;
  logic neg;
  digits_t digits;

  logic [2*ValueWidth-1:0] prod;
  logic [ValueWidth-1:0] quot;
  logic [DigitWidth-1:0] quot_x10;
  logic [DigitWidth-1:0] digit;
  logic div_done;

  assign prod = {{ValueWidth{1'b0}}, mag} * {{ValueWidth{1'b0}}, RecipTen};
  assign quot = ValueWidth'(prod >> RecipShift);
  // only the low nibble of 10*q is needed, the remainder is below ten
  assign quot_x10 = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign digit = mag[DigitWidth-1:0] - quot_x10;
  assign div_done = (quot == '0) || (nd == IdxWidth'(DigitCount - 1));

  assign s_tready = (state == StIdle);
  assign push = (state == StPush) && !q_stat.full;
  assign push_rec.neg = neg;
  assign push_rec.top = nd;
  assign push_rec.digits = digits;

  always_comb begin
    state_next = state;
    case (state)
      StIdle: begin
        if (s_tvalid) state_next = StDiv;
      end
      StDiv: begin
        if (div_done) state_next = StPush;
      end
      StPush: begin
        if (!q_stat.full) state_next = StIdle;
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == StIdle && s_tvalid) begin
      neg <= s_tdata[ValueWidth-1];
      mag <= s_tdata[ValueWidth-1] ? (~s_tdata + 1'b1) : s_tdata;
      nd <= '0;
    end else if (state == StDiv) begin
      digits[nd] <= digit;
      mag <= quot;
      if (!div_done) nd <= nd + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sidc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sidc_queue
// short first-in first-out buffer of digit records between front and back
// ----------------------------------------------------------------------------
module sidc_queue #(
  parameter int Depth = sidc_pkg::QueueDepthDefault
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire sidc_pkg::rec_t   push_rec,
  input  wire logic             pop,
  output sidc_pkg::rec_t        pop_rec,
  output sidc_pkg::qstat_t      q_stat
);
  import sidc_pkg::*;

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rec_t entries [Depth];
  logic [AddrW-1:0] wr_ptr;
  logic [AddrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic do_push;
  logic do_pop;

  assign q_stat.full = (count == FullCnt);
  assign q_stat.empty = (count == '0);
  assign do_push = push && !q_stat.full;
  assign do_pop = pop && !q_stat.empty;
  assign pop_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LastAddr) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == LastAddr) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_rec;
  end

endmodule
`default_nettype wire

// ===== rtl/sidc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sidc_back
// takes a digit record and sends sign and digits as ascii, most significant
// first, through a registered output stage
// ----------------------------------------------------------------------------
module sidc_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire sidc_pkg::qstat_t                 q_stat,
  input  wire sidc_pkg::rec_t                   pop_rec,
  output logic                                  pop,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [sidc_pkg::CharWidth-1:0]        m_tdata,   // character
  output logic                                  m_tlast
);
  import sidc_pkg::*;

  logic act;
  logic neg;
  logic [IdxWidth-1:0] idx;
  digits_t digits;
  logic advance;

  assign pop = !act && !q_stat.empty;
  assign advance = act && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        act <= 1'b1;
      end else if (advance && !neg && idx == '0) begin
        act <= 1'b0;
      end
      if (advance) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      neg <= pop_rec.neg;
      idx <= pop_rec.top;
      digits <= pop_rec.digits;
    end else if (advance) begin
      if (neg) begin
        neg <= 1'b0;
        m_tdata <= CharMinus;
        m_tlast <= 1'b0;
      end else begin
        m_tdata <= CharZero + {{(CharWidth-DigitWidth){1'b0}}, digits[idx]};
        m_tlast <= (idx == '0);
        if (idx != '0) idx <= idx - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// converts a signed 32-bit integer into its decimal ascii characters
// ----------------------------------------------------------------------------
// from accept, a value passes the digit loop, the queue hand-off, the record
//   load and the output register before its first character leaves
// front and back overlap through the queue, each working on one value at a
//   time; the slower of the two sets the rate
// reset: synchronous, clears control state; the queue comes up empty
module signed_int_to_decimal_ascii_core #(
  parameter int QueueDepth = sidc_pkg::QueueDepthDefault
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [sidc_pkg::ValueWidth-1:0]  s_tdata,   // value
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [sidc_pkg::CharWidth-1:0]        m_tdata,   // character
  output logic                                  m_tlast
);
  import sidc_pkg::*;

  qstat_t q_stat;
  rec_t push_rec;
  rec_t pop_rec;
  logic push;
  logic pop;

  sidc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  sidc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .q_stat   (q_stat)
  );

  sidc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .pop_rec  (pop_rec),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // only sign or digit codes leave the block
  a_char_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == CharMinus) ||
                 (m_tdata >= CharZero && m_tdata <= CharZero + 8'd9))
    else $error("bad character code");

  // a sign is never the end of a run
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata == CharMinus |-> !m_tlast)
    else $error("minus sign flagged last");

  // the front works one value at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("front took a second value while busy");

  // queue never reports full and empty together
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

endmodule
`default_nettype wire

// ===== sim/signed_int_to_decimal_ascii_core_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_tb
// self-checking bench for the signed integer to decimal text core: values go
// in on the slave stream, and every character beat on the master stream is
// checked against text predicted in the bench, with random gaps on both sides
// and one long receiver hold-off that backs the block up into its input
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core_tb;

  import sidc_pkg::*;

  localparam int IdleLimit = 4000;
  localparam int HoldOffCycles = 300;
  localparam int MaxPrinted = 30;

  typedef struct {
    logic [CharWidth-1:0] ch;
    logic last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [ValueWidth-1:0] s_tdata = '0;   // value
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [CharWidth-1:0] m_tdata;         // character
  logic m_tlast;

  text_char_t text_q[$];
  int error_count = 0;
  int idle_cycles = 0;
  bit src_idle_on = 1'b1;
  bit snk_idle_on = 1'b1;
  int hold_req_count = 0;
  int hold_seen_count = 0;
  int hold_left = 0;
  int stall_left = 0;

  signed_int_to_decimal_ascii_core uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // decimal text of one value: sign, then digits most significant first
  function automatic void predict_text(input logic [ValueWidth-1:0] v);
    logic neg;
    logic [ValueWidth-1:0] mag;
    logic [DigitWidth-1:0] digs[DigitCount];
    int nd;
    text_char_t c;
    neg = v[ValueWidth-1];
    mag = neg ? (~v + 1'b1) : v;
    nd = 0;
    do begin
      digs[nd] = DigitWidth'(mag % 32'd10);
      nd++;
      mag = mag / 32'd10;
    end while (mag != 0);
    if (neg) begin
      c.ch = CharMinus;
      c.last = 1'b0;
      text_q.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.ch = CharZero + CharWidth'(digs[i]);
      c.last = (i == 0);
      text_q.push_back(c);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MaxPrinted) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    end
    error_count++;
  endtask

  // input side monitor: every accepted value adds its text to the queue
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predict_text(s_tdata);
    end
  end

  // output side checker
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (text_q.size() == 0) begin
        report_mismatch("unexpected character beat", 32'(m_tdata), 32'd0);
      end else begin
        want = text_q.pop_front();
        if (m_tdata !== want.ch) begin
          report_mismatch("character", 32'(m_tdata), 32'(want.ch));
        end
        if (m_tlast !== want.last) begin
          report_mismatch("last flag", 32'(m_tlast), 32'(want.last));
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when a test asks for one
  always @(negedge clk) begin
    if (hold_req_count != hold_seen_count) begin
      hold_seen_count = hold_req_count;
      hold_left = HoldOffCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (snk_idle_on && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap();
      end
    end
  end

  // watchdog on cycles where neither side moves a beat
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_value(input logic [ValueWidth-1:0] v);
    int gap;
    gap = src_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
  endtask

  // random value with a chosen number of digits and a random sign
  function automatic logic [ValueWidth-1:0] value_with_digits(input int n);
    longint lo;
    longint hi;
    longint mag;
    bit neg;
    neg = 1'($urandom_range(0, 1));
    lo = 1;
    for (int i = 1; i < n; i++) begin
      lo = lo * 10;
    end
    hi = lo * 10 - 1;
    if (n == 1) begin
      lo = 0;
    end
    if (neg && hi > 64'd2147483648) begin
      hi = 64'd2147483648;
    end
    if (!neg && hi > 64'd2147483647) begin
      hi = 64'd2147483647;
    end
    mag = lo + longint'($urandom_range(0, 32'(hi - lo)));
    return neg ? ValueWidth'(-mag) : ValueWidth'(mag);
  endfunction

  task automatic test_directed();
    logic [ValueWidth-1:0] vals[$];
    vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
             32'd999999999, 32'd1000000000, -32'sd1000000000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0001, 32'd12345, -32'sd67890,
             32'hAAAA_AAAA, 32'h5555_5555, 32'd9999, -32'sd100000,
             32'd4294967, -32'sd5};
    foreach (vals[i]) begin
      send_value(vals[i]);
    end
  endtask

  task automatic test_random_words(input int count);
    repeat (count) send_value($urandom());
  endtask

  task automatic test_random_lengths(input int count);
    repeat (count) send_value(value_with_digits($urandom_range(1, DigitCount)));
  endtask

  // no idling on either side
  task automatic test_full_rate(input int count);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    repeat (count) send_value(value_with_digits($urandom_range(1, DigitCount)));
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure(input int count);
    src_idle_on = 1'b0;
    hold_req_count++;
    repeat (count) send_value(value_with_digits($urandom_range(1, DigitCount)));
    src_idle_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_words(140);
    test_random_lengths(140);
    test_full_rate(60);
    test_backpressure(40);
    test_random_lengths(40);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (text_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
